### rtl/tta_pkg.sv
// Shared types, widths and register codes for the tiled texture untile address block.
// Every other file of the block imports this package; it depends on nothing.
package tta_pkg;

  // Largest texture width in blocks; wider settings saturate to this value.
  localparam int MAX_WIDTH_BLOCKS = 8192;

  // Fixed field widths of the channels.
  localparam int IDX_W      = 26;
  localparam int CX_W       = 16;
  localparam int CY_W       = 16;
  localparam int SRC_W      = 30;
  localparam int DST_W      = 34;
  localparam int CFG_WID_W  = 14;
  localparam int LOG_W      = 3;
  localparam int BUFB_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_LOG    = 4;

  // Derived widths.
  localparam int WID_W     = $clog2(MAX_WIDTH_BLOCKS + 1);
  localparam int MAX_TILES = MAX_WIDTH_BLOCKS / 32;
  localparam int TILES_W   = $clog2(MAX_TILES + 1);
  localparam int REM_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int OM_W      = 17;                 // macro tile number, bounded by the index
  localparam int LOW_W     = 5;                  // coordinate bits below the macro tile
  localparam int X_W       = REM_W + LOW_W;
  localparam int Y_W       = OM_W + LOW_W;
  localparam int SUM_W     = Y_W + WID_W + 1;
  localparam int SHD_W     = SUM_W + MAX_LOG;

  // Pipelined divider: quotient bits resolved per stage and stage count.
  localparam int DIV_STEP = 4;
  localparam int DIV_STG  = (OM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W    = DIV_STG * DIV_STEP;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_LOG    = 2'd1,
    CFG_BUFFER = 2'd2
  } cfg_idx_t;

  // Effective configuration, already saturated at write time.
  typedef struct packed {
    logic [WID_W-1:0]   width;
    logic [LOG_W-1:0]   lg;
    logic [TILES_W-1:0] tiles;
    logic [BUFB_W-1:0]  buffer_bytes;
  } cfg_t;

  // Fields that ride along the divider untouched.
  typedef struct packed {
    logic [LOW_W-1:0] xlow;
    logic [LOW_W-1:0] ylow;
    logic [SRC_W-1:0] src;
  } side_t;

  typedef struct packed {
    logic [OM_W-1:0] om;
    side_t           side;
  } front_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] num;
    side_t            side;
  } div_st_t;

  typedef struct packed {
    logic [OM_W-1:0]  quo;
    logic [REM_W-1:0] rem;
    side_t            side;
  } div_res_t;

endpackage

### rtl/tta_if.sv
// Channel interfaces of the tiled texture untile address block: input, result and config.
// Depends on tta_pkg for the field widths.
interface tta_in_if;
  import tta_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] block_index;
  modport source (output valid, block_index, input ready);
  modport sink (input valid, block_index, output ready);
endinterface

interface tta_out_if;
  import tta_pkg::*;
  logic             valid;
  logic             ready;
  logic [CX_W-1:0]  coord_x;
  logic [CY_W-1:0]  coord_y;
  logic [SRC_W-1:0] source_byte_offset;
  logic [DST_W-1:0] dest_byte_offset;
  logic             in_range;
  modport source (output valid, coord_x, coord_y, source_byte_offset, dest_byte_offset,
                  in_range, input ready);
  modport sink (input valid, coord_x, coord_y, source_byte_offset, dest_byte_offset,
                in_range, output ready);
endinterface

interface tta_cfg_if;
  import tta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/tiled_texture_untile_address.sv
// Each accepted input beat passes the front register, the divider stages, the sum register and the output register.
// Throughput: one beat per cycle; the divider has one stage per four quotient bits, so
// the pipeline holds up to eight items and stalls only when the output is not taken.
// Reset (synchronous, rst_n low) empties the pipeline and sets width 1, one byte per
// texel and a zero buffer size. Configuration writes are accepted in every cycle.
module tiled_texture_untile_address (
  input  logic     clk,
  input  logic     rst_n,
  tta_in_if.sink   in_ch,
  tta_out_if.source out_ch,
  tta_cfg_if.sink  cfg_ch
);
  import tta_pkg::*;

  logic [WID_W-1:0]   width_r;
  logic [LOG_W-1:0]   lg_r;
  logic [TILES_W-1:0] tiles_r;
  logic [BUFB_W-1:0]  bufb_r;

  logic [CFG_WID_W-1:0] raw_w;
  logic [WID_W-1:0]     width_nxt;
  logic [TILES_W-1:0]   tiles_nxt;
  logic [LOG_W-1:0]     raw_lg;
  logic [LOG_W-1:0]     lg_nxt;

  cfg_t     cfg;
  logic     f_valid;
  logic     f_ready;
  front_t   f_data;
  logic     d_valid;
  logic     d_ready;
  div_res_t d_data;

  // Saturate the settings once when written so the datapath sees only legal values.
  always_comb begin
    raw_w  = cfg_ch.data[CFG_WID_W-1:0];
    raw_lg = cfg_ch.data[LOG_W-1:0];
    if (raw_w == '0) begin
      width_nxt = WID_W'(1);
    end else if (32'(raw_w) > 32'(MAX_WIDTH_BLOCKS)) begin
      width_nxt = WID_W'(MAX_WIDTH_BLOCKS);
    end else begin
      width_nxt = WID_W'(raw_w);
    end
    tiles_nxt = TILES_W'((32'(width_nxt) + 32'd31) >> 5);
    lg_nxt    = (32'(raw_lg) > MAX_LOG) ? LOG_W'(MAX_LOG) : raw_lg;
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WID_W'(1);
      lg_r    <= '0;
      tiles_r <= TILES_W'(1);
      bufb_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_WIDTH: begin
          width_r <= width_nxt;
          tiles_r <= tiles_nxt;
        end
        CFG_LOG: begin
          lg_r <= lg_nxt;
        end
        CFG_BUFFER: begin
          bufb_r <= cfg_ch.data[BUFB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.width        = width_r;
  assign cfg.lg           = lg_r;
  assign cfg.tiles        = tiles_r;
  assign cfg.buffer_bytes = bufb_r;

  tta_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_idx   (in_ch.block_index),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  tta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_data  (d_data)
  );

  tta_addr u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_valid    (d_valid),
    .up_ready    (d_ready),
    .up_data     (d_data),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .dn_coord_x  (out_ch.coord_x),
    .dn_coord_y  (out_ch.coord_y),
    .dn_src      (out_ch.source_byte_offset),
    .dn_dst      (out_ch.dest_byte_offset),
    .dn_in_range (out_ch.in_range)
  );

endmodule

### rtl/tta_front.sv
// Front stage: splits the tiled index into macro tile number and the low coordinate bits.
// Depends on tta_pkg.
module tta_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tta_pkg::cfg_t         cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [tta_pkg::IDX_W-1:0] up_idx,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output tta_pkg::front_t       dn_data
);
  import tta_pkg::*;

  localparam int OT_W = SRC_W - 2;

  logic [SRC_W-1:0] ob;
  logic [OT_W-1:0]  ot;
  logic [OT_W-1:0]  sh5;
  logic [OT_W-1:0]  sh6;
  logic [OT_W-1:0]  sh7;
  logic [1:0]       tx;
  logic [1:0]       ty;
  logic [6:0]       u7;
  logic [6:0]       ux7;
  logic [10:0]      m11;
  logic [9:0]       v10;
  logic [9:0]       uyv;
  logic [2:0]       uy;
  front_t           data_nxt;
  front_t           data_r;
  logic             v_r;

  always_comb begin
    ob  = SRC_W'(up_idx) << cfg.lg;
    // Tile bytes: the upper address bits drop three places, bits 8..10 drop two.
    ot  = OT_W'({ob[SRC_W-1:12], 9'b0}) + OT_W'({ob[10:8], 6'b0}) + OT_W'(ob[5:0]);
    sh5 = ot >> ({2'b0, cfg.lg} + 5'd5);
    sh6 = ot >> ({2'b0, cfg.lg} + 5'd6);
    sh7 = ot >> ({2'b0, cfg.lg} + 5'd7);
    tx  = {sh5[1], 1'b0} + ob[7:6];
    ty  = {ob[11], sh6[0]};
    // Micro tile column: bit 4 of the tile offset is squeezed out.
    u7  = {ot[7:5], ot[3:0]};
    ux7 = u7 >> cfg.lg;
    // Micro tile row: the masked field and the doubled low nibble never overlap.
    m11 = ((11'd64 << cfg.lg) - 11'd1) & ~11'd31;
    v10 = (ot[9:0] & m11[9:0]) | {5'b0, ot[3:0], 1'b0};
    uyv = v10 >> ({2'b0, cfg.lg} + 5'd3);
    uy  = uyv[2:0] & 3'b110;
    data_nxt.om        = sh7[OM_W-1:0];
    data_nxt.side.xlow = {tx, ux7[2:0]};
    data_nxt.side.ylow = {ty, uy[2:1], ot[4]};
    data_nxt.side.src  = ob;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

### rtl/tta_div.sv
// Pipelined restoring divider: macro tile number over tiles per row, a few bits per stage.
// Depends on tta_pkg.
module tta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tta_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  tta_pkg::front_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output tta_pkg::div_res_t dn_data
);
  import tta_pkg::*;

  localparam int CMP_W = REM_W + 2;

  logic    v_r [DIV_STG];
  logic    rdy [DIV_STG];
  div_st_t st_r [DIV_STG];

  genvar k;
  generate
    for (k = 0; k < DIV_STG; k++) begin : g_stg
      logic             in_v;
      div_st_t          in_st;
      div_st_t          step_nxt;
      logic [REM_W-1:0] rem_c;
      logic [DIV_W-1:0] num_c;
      logic [REM_W:0]   trial;
      logic [CMP_W-1:0] diff;
      logic             ge;

      if (k == 0) begin : g_head
        assign in_v       = up_valid;
        assign in_st.rem  = '0;
        assign in_st.num  = DIV_W'(up_data.om);
        assign in_st.side = up_data.side;
      end else begin : g_body
        assign in_v  = v_r[k-1];
        assign in_st = st_r[k-1];
      end

      if (k == DIV_STG - 1) begin : g_last
        assign rdy[k] = !v_r[k] || dn_ready;
      end else begin : g_mid
        assign rdy[k] = !v_r[k] || rdy[k+1];
      end

      // Quotient bits shift in at the bottom as dividend bits leave the top.
      always_comb begin
        rem_c = in_st.rem;
        num_c = in_st.num;
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        for (int j = 0; j < DIV_STEP; j++) begin
          trial = {rem_c, num_c[DIV_W-1]};
          diff  = CMP_W'(trial) - CMP_W'(cfg.tiles);
          ge    = !diff[CMP_W-1];
          num_c = {num_c[DIV_W-2:0], ge};
          rem_c = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
        step_nxt.rem  = rem_c;
        step_nxt.num  = num_c;
        step_nxt.side = in_st.side;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= in_v;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && in_v) begin
          st_r[k] <= step_nxt;
        end
      end
    end
  endgenerate

  assign up_ready     = rdy[0];
  assign dn_valid     = v_r[DIV_STG-1];
  assign dn_data.quo  = st_r[DIV_STG-1].num[OM_W-1:0];
  assign dn_data.rem  = st_r[DIV_STG-1].rem;
  assign dn_data.side = st_r[DIV_STG-1].side;

endmodule

### rtl/tta_addr.sv
// Address stages: row times width plus column, then byte scaling, range check and output register.
// Depends on tta_pkg.
module tta_addr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tta_pkg::cfg_t             cfg,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  tta_pkg::div_res_t         up_data,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [tta_pkg::CX_W-1:0]  dn_coord_x,
  output logic [tta_pkg::CY_W-1:0]  dn_coord_y,
  output logic [tta_pkg::SRC_W-1:0] dn_src,
  output logic [tta_pkg::DST_W-1:0] dn_dst,
  output logic                      dn_in_range
);
  import tta_pkg::*;

  logic [X_W-1:0]   x;
  logic [Y_W-1:0]   y;
  logic [SUM_W-1:0] sum_nxt;
  logic [SHD_W-1:0] dst_nxt;

  logic             mv_r;
  logic [SUM_W-1:0] sum_r;
  logic [X_W-1:0]   mx_r;
  logic [CY_W-1:0]  my_r;
  logic [SRC_W-1:0] msrc_r;
  logic             m_ready;

  logic             ov_r;
  logic [CX_W-1:0]  cx_r;
  logic [CY_W-1:0]  cy_r;
  logic [SRC_W-1:0] src_r;
  logic [DST_W-1:0] dst_r;
  logic             rng_r;
  logic             o_ready;

  // Macro tile quotient and remainder sit directly above the low coordinate bits.
  assign x       = {up_data.rem, up_data.side.xlow};
  assign y       = {up_data.quo, up_data.side.ylow};
  assign sum_nxt = SUM_W'(y) * SUM_W'(cfg.width) + SUM_W'(x);
  assign dst_nxt = SHD_W'(sum_r) << cfg.lg;

  assign o_ready  = !ov_r || dn_ready;
  assign m_ready  = !mv_r || o_ready;
  assign up_ready = m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (m_ready) begin
        mv_r <= up_valid;
      end
      if (o_ready) begin
        ov_r <= mv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && up_valid) begin
      sum_r  <= sum_nxt;
      mx_r   <= x;
      my_r   <= y[CY_W-1:0];
      msrc_r <= up_data.side.src;
    end
    if (o_ready && mv_r) begin
      cx_r  <= CX_W'(mx_r);
      cy_r  <= my_r;
      src_r <= msrc_r;
      dst_r <= dst_nxt[DST_W-1:0];
      // The range check uses the full offset, not the truncated field.
      rng_r <= dst_nxt < SHD_W'(cfg.buffer_bytes);
    end
  end

  assign dn_valid    = ov_r;
  assign dn_coord_x  = cx_r;
  assign dn_coord_y  = cy_r;
  assign dn_src      = src_r;
  assign dn_dst      = dst_r;
  assign dn_in_range = rng_r;

endmodule
